// File: rtl/core/bbifp_pkg.sv
// Shared constants, types and helpers for the basic-info frame parser.
package bbifp_pkg;

  // Frame store geometry
  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int FILL_W      = $clog2(STORE_DEPTH + 1);

  // Frame framing bytes and layout
  localparam logic [7:0] END_MARK = 8'h77;
  localparam logic [7:0] HEAD0    = 8'hDD;
  localparam logic [7:0] HEAD1    = 8'h03;
  localparam int MIN_LEN          = 26;
  localparam int NTC_BASE         = 27;
  localparam logic NTC_BASE_LSB   = 1'(NTC_BASE % 2);
  localparam int CHG_BIT          = 0;
  localparam int DSG_BIT          = 1;

  // Shared multiply-add unit widths
  localparam int OP_W  = 17;
  localparam int RES_W = 32;

  // Temperature conversion: raw (0.1 K) * 10 - 27315 -> 0.01 C
  localparam int TEMP_W      = 21;
  localparam int TEMP_SCALE  = 10;
  localparam int TEMP_OFFSET = -27315;
  localparam int TEMP_FLOOR  = -5000;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIX,
    ST_CAP,
    ST_NTC,
    ST_WAIT,
    ST_PWR,
    ST_PWRW
  } state_e;

  // Fixed header bytes fetched at frame end, in fetch order
  typedef enum logic [3:0] {
    FX_HEAD0,
    FX_HEAD1,
    FX_VOLT_HI,
    FX_VOLT_LO,
    FX_CUR_HI,
    FX_CUR_LO,
    FX_CAPA_HI,
    FX_CAPA_LO,
    FX_CYC_HI,
    FX_CYC_LO,
    FX_SOC,
    FX_MOS,
    FX_NTC_CNT
  } fix_idx_e;

  // What the store read returning this cycle carries
  typedef enum logic [1:0] {
    RD_NONE,
    RD_FIX,
    RD_NTC_HI,
    RD_NTC_LO
  } rd_kind_e;

  // What the shared unit result carries
  typedef enum logic [1:0] {
    AK_NONE,
    AK_TEMP,
    AK_PWR
  } alu_kind_e;

  // Store address of each fixed byte
  function automatic logic [ADDR_W-1:0] fix_addr(fix_idx_e idx);
    logic [ADDR_W-1:0] a;
    unique case (idx)
      FX_HEAD0:   a = ADDR_W'(0);
      FX_HEAD1:   a = ADDR_W'(1);
      FX_VOLT_HI: a = ADDR_W'(4);
      FX_VOLT_LO: a = ADDR_W'(5);
      FX_CUR_HI:  a = ADDR_W'(6);
      FX_CUR_LO:  a = ADDR_W'(7);
      FX_CAPA_HI: a = ADDR_W'(8);
      FX_CAPA_LO: a = ADDR_W'(9);
      FX_CYC_HI:  a = ADDR_W'(12);
      FX_CYC_LO:  a = ADDR_W'(13);
      FX_SOC:     a = ADDR_W'(23);
      FX_MOS:     a = ADDR_W'(24);
      FX_NTC_CNT: a = ADDR_W'(26);
      default:    a = '0;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/core/bbifp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bbifp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/bbifp_alu.sv
// Shared signed multiply-add unit with registered result.
module bbifp_alu (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [bbifp_pkg::OP_W-1:0]    a_i,
  input  logic signed [bbifp_pkg::OP_W-1:0]    b_i,
  input  logic signed [bbifp_pkg::RES_W-1:0]   c_i,
  output logic signed [bbifp_pkg::RES_W-1:0]   res_o
);
  import bbifp_pkg::*;

  logic signed [2*OP_W-1:0] prod_w;
  logic signed [2*OP_W-1:0] sum_w;
  logic signed [RES_W-1:0]  res_q;

  // a * b + c, kept to the result width
  assign prod_w = a_i * b_i;
  assign sum_w  = prod_w + $signed({{(2*OP_W-RES_W){c_i[RES_W-1]}}, c_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= sum_w[RES_W-1:0];
    end
  end

  assign res_o = res_q;

endmodule

// File: rtl/core/bms_basic_info_frame_parser.sv
// Top level of the battery-management basic-info frame parser.
//
// Input channel: one response byte per transfer (data_byte_i, chunk_end_i),
// in_valid_i / in_stall_o. Output channel: one decoded status record per
// frame, out_valid_o / out_stall_i. While no frame is being decoded, ordinary
// bytes are taken one per cycle and written to a 64-byte frame store.
// A transfer with chunk_end_i set on byte 0x77 closes the frame. The
// sequencer then reads 13 fixed bytes from the store (one read per cycle),
// walks the thermistor words (two reads per word) through the shared
// multiply-add unit, and finally forms pack power on the same unit. The
// thermistor count N is capped to the words the store holds; when N is 0 the
// walk is skipped, and a rejected frame reports as soon as the count byte is
// read, without the walk or power step. Input is stalled while a frame is
// being decoded; the steps share the store read port and the single unit.
// When the receiver stalls, the result is held in the output register;
// ordinary bytes are still taken, but a closing byte waits until the
// pending result is transferred.
// Reset clears the fill count and drops any pending result; the store
// contents are left as they are.
module bms_basic_info_frame_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               chunk_end_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               frame_status_o,
  output logic [15:0]        voltage_centivolts_o,
  output logic signed [15:0] current_centiamps_o,
  output logic [15:0]        capacity_centiamphours_o,
  output logic [15:0]        cycle_total_o,
  output logic [7:0]         charge_percent_o,
  output logic               charge_switch_on_o,
  output logic               discharge_switch_on_o,
  output logic signed [31:0] power_units_o,
  output logic signed [20:0] peak_temp_centicelsius_o
);
  import bbifp_pkg::*;

  localparam logic signed [TEMP_W-1:0] TEMP_FLOOR_V = TEMP_W'(TEMP_FLOOR);

  state_e               state_q, state_d;
  fix_idx_e             idx_q, idx_d;
  logic [FILL_W-1:0]    fill_q, fill_d;
  logic [FILL_W-1:0]    ptr_q, ptr_d;
  logic [FILL_W-1:0]    ntc_end_q, ntc_end_d;
  logic                 out_valid_q, out_valid_d;
  logic                 status_q, status_d;
  rd_kind_e             rd_kind_q, rd_kind_d;
  fix_idx_e             rd_idx_q;
  alu_kind_e            alu_kind_q, alu_kind_d;
  logic                 any_q;
  logic signed [TEMP_W-1:0] peak_q;

  logic [7:0]  head0_q, head1_q, soc_q, ntc_hi_q;
  logic [15:0] volt_q, capa_q, cyc_q;
  logic [15:0] cur_q;
  logic [1:0]  mos_q;
  logic signed [RES_W-1:0] pwr_q;

  logic              in_acc;
  logic              end_byte;
  logic              store_we;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              frame_ok;
  logic [FILL_W-1:0] cap_w;
  logic [7:0]        cnt_w;

  logic                    alu_en;
  logic signed [OP_W-1:0]  alu_a, alu_b;
  logic signed [RES_W-1:0] alu_c;
  logic signed [RES_W-1:0] alu_res;
  logic signed [TEMP_W-1:0] temp_w;
  logic                    temp_ok;

  // Input handshake
  assign end_byte   = chunk_end_i && (data_byte_i == END_MARK);
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && end_byte);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign store_we   = in_acc && (fill_q < FILL_W'(STORE_DEPTH));

  // Frame store
  bbifp_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (store_we),
    .waddr_i(fill_q[ADDR_W-1:0]),
    .wdata_i(data_byte_i),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  // Header check and capped thermistor count, used when the count byte returns
  assign frame_ok = (fill_q > FILL_W'(MIN_LEN)) && (head0_q == HEAD0) && (head1_q == HEAD1);
  assign cap_w    = (fill_q > FILL_W'(NTC_BASE)) ?
                    ((fill_q - FILL_W'(NTC_BASE)) >> 1) : '0;
  assign cnt_w    = (rd_data > 8'(cap_w)) ? 8'(cap_w) : rd_data;

  // Sequencer: next state, store reads, fill count, result flag
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    ptr_d       = ptr_q;
    ntc_end_d   = ntc_end_q;
    status_d    = status_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    rd_kind_d   = RD_NONE;
    fill_d      = fill_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (store_we) begin
      fill_d = fill_q + FILL_W'(1);
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && end_byte) begin
          state_d = ST_FIX;
          idx_d   = FX_HEAD0;
        end
      end
      ST_FIX: begin
        rd_en     = 1'b1;
        rd_addr   = fix_addr(idx_q);
        rd_kind_d = RD_FIX;
        if (idx_q == FX_NTC_CNT) begin
          state_d = ST_CAP;
        end else begin
          idx_d = fix_idx_e'(idx_q + 4'd1);
        end
      end
      ST_CAP: begin
        ptr_d     = FILL_W'(NTC_BASE);
        ntc_end_d = FILL_W'(NTC_BASE) + FILL_W'({cnt_w, 1'b0});
        if (!frame_ok) begin
          status_d    = 1'b1;
          out_valid_d = 1'b1;
          fill_d      = '0;
          state_d     = ST_IDLE;
        end else if (cnt_w == 8'd0) begin
          status_d = 1'b0;
          state_d  = ST_PWR;
        end else begin
          status_d = 1'b0;
          state_d  = ST_NTC;
        end
      end
      ST_NTC: begin
        rd_en     = 1'b1;
        rd_addr   = ptr_q[ADDR_W-1:0];
        rd_kind_d = (ptr_q[0] == NTC_BASE_LSB) ? RD_NTC_HI : RD_NTC_LO;
        ptr_d     = ptr_q + FILL_W'(1);
        if (ptr_d == ntc_end_q) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_d = ST_PWR;
      end
      ST_PWR: begin
        state_d = ST_PWRW;
      end
      ST_PWRW: begin
        out_valid_d = 1'b1;
        fill_d      = '0;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Shared unit operand select: thermistor scaling or pack power
  always_comb begin
    alu_en     = 1'b0;
    alu_kind_d = AK_NONE;
    alu_a      = '0;
    alu_b      = '0;
    alu_c      = '0;
    priority if (rd_kind_q == RD_NTC_LO) begin
      alu_en     = 1'b1;
      alu_kind_d = AK_TEMP;
      alu_a      = $signed({1'b0, ntc_hi_q, rd_data});
      alu_b      = OP_W'(TEMP_SCALE);
      alu_c      = RES_W'(TEMP_OFFSET);
    end else if (state_q == ST_PWR) begin
      alu_en     = 1'b1;
      alu_kind_d = AK_PWR;
      alu_a      = $signed({1'b0, volt_q});
      alu_b      = $signed({cur_q[15], cur_q});
      alu_c      = '0;
    end
  end

  bbifp_alu u_alu (
    .clk_i(clk_i),
    .en_i (alu_en),
    .a_i  (alu_a),
    .b_i  (alu_b),
    .c_i  (alu_c),
    .res_o(alu_res)
  );

  assign temp_w = $signed(alu_res[TEMP_W-1:0]);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= FX_HEAD0;
      fill_q      <= '0;
      ptr_q       <= '0;
      ntc_end_q   <= '0;
      out_valid_q <= 1'b0;
      status_q    <= 1'b0;
      rd_kind_q   <= RD_NONE;
      rd_idx_q    <= FX_HEAD0;
      alu_kind_q  <= AK_NONE;
      any_q       <= 1'b0;
      peak_q      <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      fill_q      <= fill_d;
      ptr_q       <= ptr_d;
      ntc_end_q   <= ntc_end_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      rd_kind_q   <= rd_kind_d;
      rd_idx_q    <= idx_q;
      alu_kind_q  <= alu_kind_d;
      // running maximum of converted thermistor readings
      if (state_q == ST_CAP) begin
        any_q <= 1'b0;
      end else if ((alu_kind_q == AK_TEMP) && (!any_q || (temp_w > peak_q))) begin
        any_q  <= 1'b1;
        peak_q <= temp_w;
      end
    end
  end

  // Captured frame fields
  always_ff @(posedge clk_i) begin
    if (rd_kind_q == RD_FIX) begin
      unique case (rd_idx_q)
        FX_HEAD0:   head0_q       <= rd_data;
        FX_HEAD1:   head1_q       <= rd_data;
        FX_VOLT_HI: volt_q[15:8]  <= rd_data;
        FX_VOLT_LO: volt_q[7:0]   <= rd_data;
        FX_CUR_HI:  cur_q[15:8]   <= rd_data;
        FX_CUR_LO:  cur_q[7:0]    <= rd_data;
        FX_CAPA_HI: capa_q[15:8]  <= rd_data;
        FX_CAPA_LO: capa_q[7:0]   <= rd_data;
        FX_CYC_HI:  cyc_q[15:8]   <= rd_data;
        FX_CYC_LO:  cyc_q[7:0]    <= rd_data;
        FX_SOC:     soc_q         <= rd_data;
        FX_MOS:     mos_q         <= rd_data[1:0];
        default:    ;
      endcase
    end
    if (rd_kind_q == RD_NTC_HI) begin
      ntc_hi_q <= rd_data;
    end
    if (alu_kind_q == AK_PWR) begin
      pwr_q <= alu_res;
    end
  end

  // Result fields; a rejected frame reports zeros
  assign temp_ok                  = any_q && (peak_q > TEMP_FLOOR_V);
  assign out_valid_o              = out_valid_q;
  assign frame_status_o           = status_q;
  assign voltage_centivolts_o     = status_q ? '0 : volt_q;
  assign current_centiamps_o      = status_q ? '0 : $signed(cur_q);
  assign capacity_centiamphours_o = status_q ? '0 : capa_q;
  assign cycle_total_o            = status_q ? '0 : cyc_q;
  assign charge_percent_o         = status_q ? '0 : soc_q;
  assign charge_switch_on_o       = !status_q && mos_q[CHG_BIT];
  assign discharge_switch_on_o    = !status_q && mos_q[DSG_BIT];
  assign power_units_o            = status_q ? '0 : pwr_q;
  assign peak_temp_centicelsius_o = (status_q || !temp_ok) ? '0 : peak_q;

`ifndef SYNTH
  // Fill count never runs past the store
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(STORE_DEPTH))
    else $error("fill count beyond store depth");

  // A closing byte always starts the header fetch
  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && end_byte) |=> (state_q == ST_FIX))
    else $error("frame end did not start decode");

  // A result appears only at the end of a decode
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (($past(state_q) == ST_CAP) || ($past(state_q) == ST_PWRW)))
    else $error("result raised outside decode end");

  // A rejected frame carries zero payload
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_status_o) |->
      ((voltage_centivolts_o == '0) && (power_units_o == '0) &&
       (peak_temp_centicelsius_o == '0)))
    else $error("rejected frame with nonzero fields");
`endif

endmodule
